[rtl/core/idll_pkg.sv]
// shared types, field layouts and codes for the indexed doubly linked list engine
package idll_pkg;

   // field widths
   localparam int ActionWidth = 3;
   localparam int LinkWidth   = 11;
   localparam int ValueWidth  = 32;
   localparam int IndexWidth  = 10;
   localparam int StatusWidth = 2;

   // stream data widths, padded to whole bytes
   localparam int ReqFieldBits = ActionWidth + 3 * LinkWidth + ValueWidth;
   localparam int ReqDataWidth = ((ReqFieldBits + 7) / 8) * 8;
   localparam int RspFieldBits = IndexWidth + ValueWidth + StatusWidth;
   localparam int RspDataWidth = ((RspFieldBits + 7) / 8) * 8;

   // table sizing
   localparam int DefaultTableDepth = 1024;
   localparam int IndexLimit        = 1024;

   // link value that names the sentinel
   localparam logic [LinkWidth-1:0] SentinelLink = '1;

   // action codes
   localparam logic [ActionWidth-1:0] ActBegin     = 3'd0;
   localparam logic [ActionWidth-1:0] ActLoad      = 3'd1;
   localparam logic [ActionWidth-1:0] ActInsAfter  = 3'd2;
   localparam logic [ActionWidth-1:0] ActInsBefore = 3'd3;
   localparam logic [ActionWidth-1:0] ActDelete    = 3'd4;
   localparam logic [ActionWidth-1:0] ActRewind    = 3'd5;
   localparam logic [ActionWidth-1:0] ActWalk      = 3'd6;

   // status codes
   localparam logic [StatusWidth-1:0] StatusOk      = 2'd0;
   localparam logic [StatusWidth-1:0] StatusFull    = 2'd1;
   localparam logic [StatusWidth-1:0] StatusListEnd = 2'd2;

   // request payload, first field in the lowest bits
   typedef struct packed {
      logic [ReqDataWidth-ReqFieldBits-1:0] pad;
      logic signed [LinkWidth-1:0]          prev_link;
      logic signed [LinkWidth-1:0]          next_link;
      logic signed [ValueWidth-1:0]         item_value;
      logic signed [LinkWidth-1:0]          anchor_index;
      logic [ActionWidth-1:0]               action;
   } idll_req_type;

   // response payload, first field in the lowest bits
   typedef struct packed {
      logic [RspDataWidth-RspFieldBits-1:0] pad;
      logic [StatusWidth-1:0]               status;
      logic signed [ValueWidth-1:0]         node_value;
      logic [IndexWidth-1:0]                new_index;
   } idll_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;      // take request, issue anchor and cursor reads
      logic do_begin;    // set head and tail, park the cursor, clear allocator
      logic do_rewind;   // park the cursor on the sentinel
      logic do_load;     // write a fresh slot from the request
      logic mark_full;   // answer table full
      logic link_first;  // insert: splice neighbor and fill new slot
      logic link_second; // insert: point anchor at new slot
      logic unlink;      // delete: bridge the two neighbors
      logic walk_next;   // walk: follow the cursor link
      logic walk_value;  // walk: take the value of the reached node
      logic publish;     // move the result into the output register
   } idll_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic walk_hit;
      logic rsp_free;
   } idll_stat_type;

endpackage

[rtl/core/idll_ctrl.sv]
// sequencer that steps each request through its table accesses
module idll_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [idll_pkg::ActionWidth-1:0]       req_action,
   input  idll_pkg::idll_stat_type                stat,
   output idll_pkg::idll_cmd_type                 cmd
);
   import idll_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE        = 7'b0000001,
      ST_LINK_FIRST  = 7'b0000010,
      ST_LINK_SECOND = 7'b0000100,
      ST_UNLINK      = 7'b0001000,
      ST_WALK_NEXT   = 7'b0010000,
      ST_WALK_VALUE  = 7'b0100000,
      ST_DONE        = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   state_type start_state;
   logic      accept;
   logic      allocates;

   // first state of a new request
   always_comb begin
      start_state = ST_DONE;
      allocates   = 1'b0;
      unique case (req_action) inside
         ActLoad: begin
            allocates = 1'b1;
         end
         ActInsAfter, ActInsBefore: begin
            allocates   = 1'b1;
            start_state = stat.full ? ST_DONE : ST_LINK_FIRST;
         end
         ActDelete: begin
            start_state = ST_UNLINK;
         end
         ActWalk: begin
            start_state = ST_WALK_NEXT;
         end
         default: begin
            start_state = ST_DONE;
         end
      endcase
   end

   // handshake and commands
   always_comb begin
      cmd             = '0;
      cmd.publish     = (state_ff == ST_DONE) && stat.rsp_free;
      req_tready      = (state_ff == ST_IDLE) || cmd.publish;
      accept          = req_tvalid && req_tready;
      cmd.accept      = accept;
      cmd.do_begin    = accept && (req_action == ActBegin);
      cmd.do_rewind   = accept && (req_action == ActRewind);
      cmd.do_load     = accept && (req_action == ActLoad) && !stat.full;
      cmd.mark_full   = accept && allocates && stat.full;
      cmd.link_first  = (state_ff == ST_LINK_FIRST);
      cmd.link_second = (state_ff == ST_LINK_SECOND);
      cmd.unlink      = (state_ff == ST_UNLINK);
      cmd.walk_next   = (state_ff == ST_WALK_NEXT);
      cmd.walk_value  = (state_ff == ST_WALK_VALUE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = start_state;
         end
         ST_LINK_FIRST: begin
            state_in = ST_LINK_SECOND;
         end
         ST_LINK_SECOND: begin
            state_in = ST_DONE;
         end
         ST_UNLINK: begin
            state_in = ST_DONE;
         end
         ST_WALK_NEXT: begin
            state_in = stat.walk_hit ? ST_WALK_VALUE : ST_DONE;
         end
         ST_WALK_VALUE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (accept) begin
               state_in = start_state;
            end else if (cmd.publish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/idll_dp.sv]
// link, value and control registers plus the three node memories
module idll_dp #(
   parameter int TABLE_DEPTH = idll_pkg::DefaultTableDepth
) (
   input  logic                                clock,
   input  logic                                reset,
   input  idll_pkg::idll_req_type              req_data,
   input  idll_pkg::idll_cmd_type              cmd,
   output idll_pkg::idll_stat_type             stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [idll_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import idll_pkg::*;

   localparam int Capacity   = (TABLE_DEPTH < IndexLimit) ? TABLE_DEPTH : IndexLimit;
   localparam int AddrWidth  = $clog2(Capacity);
   localparam int CountWidth = $clog2(Capacity + 1);

   // node memories, no reset
   logic [ValueWidth-1:0] value_mem [Capacity];
   logic [LinkWidth-1:0]  next_mem  [Capacity];
   logic [LinkWidth-1:0]  prev_mem  [Capacity];

   logic [ValueWidth-1:0] value_rd_ff;
   logic [LinkWidth-1:0]  next_rd_ff;
   logic [LinkWidth-1:0]  prev_rd_ff;

   // control registers
   logic [LinkWidth-1:0]  head_ff, head_in;
   logic [LinkWidth-1:0]  tail_ff, tail_in;
   logic [LinkWidth-1:0]  cursor_ff, cursor_in;
   logic [CountWidth-1:0] alloc_ff, alloc_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request and result holding registers
   logic [LinkWidth-1:0]   anchor_ff;
   logic [ValueWidth-1:0]  item_value_ff;
   logic                   after_ff;
   logic [IndexWidth-1:0]  res_index_ff, res_index_in;
   logic [ValueWidth-1:0]  res_value_ff, res_value_in;
   logic [StatusWidth-1:0] res_status_ff, res_status_in;
   idll_rsp_type           rsp_data_ff;

   // memory ports
   logic                  next_we, prev_we, value_we;
   logic [AddrWidth-1:0]  next_waddr, prev_waddr, value_waddr;
   logic [LinkWidth-1:0]  next_wdata, prev_wdata;
   logic [ValueWidth-1:0] value_wdata;
   logic                  next_re, value_re;
   logic [AddrWidth-1:0]  next_raddr, prev_raddr, value_raddr;

   // decoded links
   logic [AddrWidth-1:0]  new_slot;
   logic [LinkWidth-1:0]  new_link;
   logic                  anchor_node;
   logic [LinkWidth-1:0]  next_of_anchor, prev_of_anchor;
   logic [LinkWidth-1:0]  splice_link;
   logic                  splice_node;
   logic [LinkWidth-1:0]  walk_link;
   logic                  walk_node;

   // a link names a stored node only when non-negative and inside the table
   function automatic logic is_node(input logic [LinkWidth-1:0] link);
      return !link[LinkWidth-1] && ({1'b0, link[LinkWidth-2:0]} < LinkWidth'(Capacity));
   endfunction

   function automatic logic [AddrWidth-1:0] slot_of(input logic [LinkWidth-1:0] link);
      return link[AddrWidth-1:0];
   endfunction

   // neighbor links, the sentinel reads through head and tail
   always_comb begin
      new_slot       = alloc_ff[AddrWidth-1:0];
      new_link       = LinkWidth'(new_slot);
      anchor_node    = is_node(anchor_ff);
      next_of_anchor = anchor_node ? next_rd_ff : head_ff;
      prev_of_anchor = anchor_node ? prev_rd_ff : tail_ff;
      splice_link    = after_ff ? next_of_anchor : prev_of_anchor;
      splice_node    = is_node(splice_link);
      walk_link      = is_node(cursor_ff) ? next_rd_ff : head_ff;
      walk_node      = is_node(walk_link);
   end

   // status to the controller
   always_comb begin
      stat.full     = (alloc_ff >= CountWidth'(Capacity));
      stat.walk_hit = walk_node;
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   // read ports
   always_comb begin
      next_re     = cmd.accept;
      value_re    = cmd.accept || cmd.walk_next;
      next_raddr  = (req_data.action == ActWalk) ? slot_of(cursor_ff)
                                                 : slot_of(req_data.anchor_index);
      prev_raddr  = slot_of(req_data.anchor_index);
      value_raddr = cmd.walk_next ? slot_of(walk_link) : slot_of(req_data.anchor_index);
   end

   // successor store writes
   always_comb begin
      next_we    = 1'b0;
      next_waddr = new_slot;
      next_wdata = new_link;
      if (cmd.do_load) begin
         next_we    = 1'b1;
         next_wdata = req_data.next_link;
      end else if (cmd.link_first) begin
         if (after_ff) begin
            next_we    = 1'b1;
            next_wdata = splice_link;
         end else begin
            next_we    = splice_node;
            next_waddr = slot_of(splice_link);
         end
      end else if (cmd.link_second) begin
         if (after_ff) begin
            next_we    = anchor_node;
            next_waddr = slot_of(anchor_ff);
         end else begin
            next_we    = 1'b1;
            next_wdata = anchor_ff;
         end
      end else if (cmd.unlink) begin
         next_we    = is_node(prev_of_anchor);
         next_waddr = slot_of(prev_of_anchor);
         next_wdata = next_of_anchor;
      end
   end

   // predecessor store writes
   always_comb begin
      prev_we    = 1'b0;
      prev_waddr = new_slot;
      prev_wdata = new_link;
      if (cmd.do_load) begin
         prev_we    = 1'b1;
         prev_wdata = req_data.prev_link;
      end else if (cmd.link_first) begin
         if (after_ff) begin
            prev_we    = splice_node;
            prev_waddr = slot_of(splice_link);
         end else begin
            prev_we    = 1'b1;
            prev_wdata = splice_link;
         end
      end else if (cmd.link_second) begin
         if (after_ff) begin
            prev_we    = 1'b1;
            prev_wdata = anchor_ff;
         end else begin
            prev_we    = anchor_node;
            prev_waddr = slot_of(anchor_ff);
         end
      end else if (cmd.unlink) begin
         prev_we    = is_node(next_of_anchor);
         prev_waddr = slot_of(next_of_anchor);
         prev_wdata = prev_of_anchor;
      end
   end

   // value store writes
   always_comb begin
      value_we    = cmd.do_load || cmd.link_first;
      value_waddr = new_slot;
      value_wdata = cmd.do_load ? req_data.item_value : item_value_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (next_re) next_rd_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      if (next_re) prev_rd_ff <= prev_mem[prev_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) value_mem[value_waddr] <= value_wdata;
      if (value_re) value_rd_ff <= value_mem[value_raddr];
   end

   // head, tail, allocator and cursor
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      alloc_in  = alloc_ff;
      cursor_in = cursor_ff;
      if (cmd.do_begin) begin
         head_in   = req_data.next_link;
         tail_in   = req_data.prev_link;
         alloc_in  = '0;
         cursor_in = SentinelLink;
      end
      if (cmd.do_rewind) cursor_in = SentinelLink;
      if (cmd.do_load || cmd.link_second) alloc_in = alloc_ff + CountWidth'(1);
      if (cmd.link_first) begin
         if (after_ff && !splice_node) tail_in = new_link;
         if (!after_ff && !splice_node) head_in = new_link;
      end
      if (cmd.link_second) begin
         if (after_ff && !anchor_node) head_in = new_link;
         if (!after_ff && !anchor_node) tail_in = new_link;
      end
      if (cmd.unlink) begin
         if (!is_node(prev_of_anchor)) head_in = next_of_anchor;
         if (!is_node(next_of_anchor)) tail_in = prev_of_anchor;
      end
      if (cmd.walk_next) cursor_in = walk_node ? walk_link : SentinelLink;
   end

   // result fields
   always_comb begin
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         res_index_in  = '0;
         res_value_in  = '0;
         res_status_in = StatusOk;
      end
      if (cmd.do_load || cmd.link_second) res_index_in = IndexWidth'(new_slot);
      if (cmd.mark_full) res_status_in = StatusFull;
      if (cmd.unlink) res_value_in = anchor_node ? value_rd_ff : '0;
      if (cmd.walk_next && !walk_node) res_status_in = StatusListEnd;
      if (cmd.walk_value) res_value_in = value_rd_ff;
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.publish) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= SentinelLink;
         tail_ff      <= SentinelLink;
         cursor_ff    <= SentinelLink;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         anchor_ff     <= req_data.anchor_index;
         item_value_ff <= req_data.item_value;
         after_ff      <= (req_data.action == ActInsAfter);
      end
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (cmd.publish) begin
         rsp_data_ff.pad        <= '0;
         rsp_data_ff.status     <= res_status_ff;
         rsp_data_ff.node_value <= res_value_ff;
         rsp_data_ff.new_index  <= res_index_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/indexed_doubly_linked_list.sv]
// top level of the indexed doubly linked list engine
// A doubly linked list held in three index-addressed memories (value, successor,
// predecessor), with head and tail registers standing in for the sentinel node
// that any negative or out-of-table link names. Each request gives exactly one
// response. Items are handled one at a time; the request port takes the next
// item in the cycle the previous response is loaded into the output register,
// which needs that register empty or handing its response on in the same cycle.
// Steps per item: begin, rewind, load and full answers go straight to the
// response; delete reads the anchor, then writes both neighbors; insert reads
// the anchor, splices the neighbor and the new slot, then writes the anchor;
// walk reads the cursor link, then the value, and skips the value read at
// the list end. The steps are set by the registered read and the single write
// port of each memory. The memories need no clearing pass: a user must never
// read an entry that has not been written; the block itself does not enforce it.
module indexed_doubly_linked_list #(
   parameter int TABLE_DEPTH = idll_pkg::DefaultTableDepth
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: action, anchor_index, item_value, next_link, prev_link
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [idll_pkg::ReqDataWidth-1:0]   req_tdata,
   // response: new_index, node_value, status
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [idll_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import idll_pkg::*;

   idll_req_type  req_data;
   idll_cmd_type  cmd;
   idll_stat_type stat;

   assign req_data = req_tdata;

   // sequencer
   idll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_data.action),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table datapath
   idll_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // at most one table operation per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_begin, cmd.do_rewind, cmd.do_load, cmd.mark_full, cmd.link_first,
                cmd.link_second, cmd.unlink, cmd.walk_next, cmd.walk_value}))
      else $error("more than one table operation in a cycle");

   // an insert splice is always followed by the anchor write
   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.link_first |=> cmd.link_second)
      else $error("insert splice not followed by anchor write");

   // a walk that reaches a node reads its value next
   a_walk_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_next && stat.walk_hit |=> cmd.walk_value)
      else $error("walk hit not followed by value read");

   // a published result shows on the response port
   a_publish: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_tvalid)
      else $error("published result missing on response port");

endmodule
